FILE: hdl/set_assoc_cache_tag_controller_unit_defines.svh
// Assertion macros for the cache tag controller checker.
// Sampled on clk_i; the first form is disabled while rst_ni is low.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH

// Property checked out of reset only.
`define SACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SACC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/sacc_pkg.sv
// Shared types and constants for the cache tag controller.
// No dependencies; used by every module of the block but sacc_tag_ram.
`timescale 1ns / 1ps
`default_nettype none

package sacc_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 30;
  localparam int WAYF_W     = 3;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [LFSR_W-1:0] LFSR_POLY = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  localparam logic [2:0] OB_MIN = 3'd2;
  localparam logic [2:0] OB_MAX = 3'd5;

  // register reset values
  localparam logic [3:0] WAYS_RST   = 4'd1;
  localparam logic [2:0] OBITS_RST  = 3'd2;
  localparam logic [2:0] IBITS_RST  = 3'd0;
  localparam logic       RND_RST    = 1'b0;
  localparam logic       WBACK_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAYS   = 3'd0,
    CFG_OFFSET = 3'd1,
    CFG_INDEX  = 3'd2,
    CFG_RANDOM = 3'd3,
    CFG_WBACK  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] ways;    // raw, zero means bypass
    logic [2:0] obits;   // limited to 2..5
    logic [2:0] ibits;   // limited to the set count
    logic       rnd;
    logic       wback;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              mode;
  } in_t;

  typedef struct packed {
    logic              bypass;
    logic              hit;
    logic [WAYF_W-1:0] way_used;
    logic              fill_needed;
    logic [ADDR_W-1:0] line_address;
    logic              writeback_needed;
    logic [ADDR_W-1:0] writeback_address;
    logic              word_write_through;
  } out_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic             recent;
  } way_ent_t;

  typedef struct packed {
    logic row_we;
    logic lfsr_step;
  } lk_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sacc_cfg_regs.sv
// Configuration registers with range limiting of the offset and index widths.
// Depends on sacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacc_cfg_regs
  import sacc_pkg::*;
#(
  parameter int MAX_SETS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam logic [2:0] IB_LIM = 3'((IB_MAX > 7) ? 7 : IB_MAX);

  logic [3:0] ways_q;
  logic [2:0] obits_q;
  logic [2:0] ibits_q;
  logic       rnd_q;
  logic       wback_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q  <= WAYS_RST;
      obits_q <= OBITS_RST;
      ibits_q <= IBITS_RST;
      rnd_q   <= RND_RST;
      wback_q <= WBACK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WAYS:   ways_q  <= cfg_data_i;
        CFG_OFFSET: obits_q <= cfg_data_i[2:0];
        CFG_INDEX:  ibits_q <= cfg_data_i[2:0];
        CFG_RANDOM: rnd_q   <= cfg_data_i[0];
        CFG_WBACK:  wback_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_o.ways  = ways_q;
    cfg_o.obits = (obits_q < OB_MIN) ? OB_MIN : ((obits_q > OB_MAX) ? OB_MAX : obits_q);
    cfg_o.ibits = (ibits_q > IB_LIM) ? IB_LIM : ibits_q;
    cfg_o.rnd   = rnd_q;
    cfg_o.wback = wback_q;
  end

endmodule

`default_nettype wire

FILE: hdl/sacc_tag_ram.sv
// One-row-per-set status memory: one write and one registered read per cycle.
// Row-valid flops make unwritten rows read as zero; a same-cycle write is forwarded.
`timescale 1ns / 1ps
`default_nettype none

module sacc_tag_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 264,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] rvalid_q;
  logic [WIDTH-1:0] rdata_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             rvld_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= '0;
      rvld_q   <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (we_i) begin
        rvalid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= rvalid_q[raddr_i];
        // the array read above sees the old row when both hit one set
        fwd_q  <= we_i && (waddr_i == raddr_i);
      end
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : (rvld_q ? rdata_q : '0);

endmodule

`default_nettype wire

FILE: hdl/sacc_victim.sv
// Random victim source: 16-bit Galois LFSR and its residue modulo the ways in use.
// Depends on sacc_pkg. Residue is built from per-nibble constant tables.
`timescale 1ns / 1ps
`default_nettype none

module sacc_victim
  import sacc_pkg::*;
#(
  parameter  int MAX_WAYS = 8,
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [WAY_W-1:0] wsel_i,     // ways in use minus one
  output logic [WAY_W-1:0] residue_o
);

  logic [LFSR_W-1:0] lfsr_q;
  logic [LFSR_W-1:0] lfsr_d;
  logic [3:0]        res_w [MAX_WAYS];

  assign lfsr_d = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_POLY : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
    end else if (step_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  // value mod d = sum of (nibble * 16^i) mod d, then at most two corrections
  for (genvar gw = 0; gw < MAX_WAYS; gw++) begin : g_div
    localparam int DIV = gw + 1;
    logic [3:0] term [4];
    logic [5:0] sum;
    logic [5:0] part;
    for (genvar gi = 0; gi < 4; gi++) begin : g_nib
      logic [63:0] rom;
      for (genvar gn = 0; gn < 16; gn++) begin : g_ent
        localparam int R = (gn * (16 ** gi)) % DIV;
        assign rom[4*gn +: 4] = 4'(R);
      end
      assign term[gi] = rom[4*lfsr_d[4*gi +: 4] +: 4];
    end
    always_comb begin
      sum = 6'(term[0]) + 6'(term[1]) + 6'(term[2]) + 6'(term[3]);
      part = (sum >= 6'(2 * DIV)) ? (sum - 6'(2 * DIV)) : sum;
      res_w[gw] = (part >= 6'(DIV)) ? 4'(part - 6'(DIV)) : 4'(part);
    end
  end

  assign residue_o = WAY_W'(res_w[wsel_i]);

endmodule

`default_nettype wire

FILE: hdl/sacc_lookup.sv
// Tag compare, victim choice and status update for one access against one set row.
// Depends on sacc_pkg. Purely combinational; registers sit in the top level.
`timescale 1ns / 1ps
`default_nettype none

module sacc_lookup
  import sacc_pkg::*;
#(
  parameter  int MAX_SETS  = 64,
  parameter  int MAX_WAYS  = 8,
  parameter  int ADDR_BITS = 32,
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1),
  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int ROW_W     = MAX_WAYS * $bits(way_ent_t)
) (
  input  cfg_t              cfg_i,
  input  logic [WCNT_W-1:0] ways_eff_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              write_i,
  input  logic [SET_W-1:0]  set_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [WAY_W-1:0]  residue_i,
  output logic [ROW_W-1:0]  row_o,
  output out_t              res_o,
  output lk_ctl_t           ctl_o
);

  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  way_ent_t [MAX_WAYS-1:0] row_ent;
  way_ent_t [MAX_WAYS-1:0] ent_new;
  logic     [MAX_WAYS-1:0] in_use;
  logic                    found;
  logic     [WAY_W-1:0]    hit_way;
  logic     [WAY_W-1:0]    clr_way;
  logic     [WAY_W-1:0]    victim;
  way_ent_t                vic_ent;

  assign row_ent = row_i;
  assign row_o   = ent_new;

  for (genvar gw = 0; gw < MAX_WAYS; gw++) begin : g_use
    assign in_use[gw] = (WCNT_W'(gw) < ways_eff_i);
  end

  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    clr_way = '0;
    // highest matching way wins
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && row_ent[w].valid && (row_ent[w].tag == tag_i)) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // lowest way with recency clear, way 0 when none
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && !row_ent[w].recent) begin
        clr_way = WAY_W'(w);
      end
    end
  end

  assign victim  = found ? hit_way : (cfg_i.rnd ? residue_i : clr_way);
  assign vic_ent = row_ent[victim];

  always_comb begin
    ent_new = row_ent;
    res_o   = '0;
    ctl_o   = '0;
    if (cfg_i.ways == '0) begin
      res_o.bypass = 1'b1;
    end else begin
      res_o.hit          = found;
      res_o.way_used     = WAYF_W'(victim);
      res_o.line_address = addr_i & ({ADDR_W{1'b1}} << cfg_i.obits);
      ctl_o.row_we       = 1'b1;
      ctl_o.lfsr_step    = !found && cfg_i.rnd;
      if (found) begin
        if (write_i) begin
          if (cfg_i.wback) begin
            ent_new[victim].dirty = 1'b1;
          end else begin
            res_o.word_write_through = 1'b1;
          end
        end
      end else if (write_i && !cfg_i.wback) begin
        // write-through miss: no allocate
        res_o.word_write_through = 1'b1;
      end else begin
        res_o.fill_needed = 1'b1;
        if (vic_ent.valid && vic_ent.dirty) begin
          res_o.writeback_needed  = 1'b1;
          res_o.writeback_address = (((ADDR_W'(vic_ent.tag) << cfg_i.ibits) |
                                      ADDR_W'(set_i)) << cfg_i.obits) & ADDR_MASK;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (in_use[w]) begin
            ent_new[w].recent = 1'b0;
          end
        end
        ent_new[victim].tag    = tag_i;
        ent_new[victim].valid  = 1'b1;
        ent_new[victim].dirty  = write_i;
        ent_new[victim].recent = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/set_assoc_cache_tag_controller_unit.sv
// Set-associative cache tag controller. Each access address is split into offset, set and
// tag at the input register, the set's status row is read from a one-read one-write memory,
// and then tags are compared, the way is picked and the updated row is written back as the
// result goes into the output register, once that register can take it. The block takes one
// access per clock while the output is not stalled; a single set row is read and rewritten per
// access (not in bypass), with a write to the set just read forwarded so back-to-back
// accesses to one set see each other. Tag, valid, dirty and recency state read as zero after
// reset through per-set valid flops, so no clearing pass is needed and items are taken at once.
// Configuration must only be written while no access is in flight.
//
// Top level. Depends on sacc_pkg, sacc_cfg_regs, sacc_tag_ram, sacc_victim, sacc_lookup.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_controller_unit
  import sacc_pkg::*;
#(
  parameter int MAX_SETS  = 64,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ROW_W  = MAX_WAYS * $bits(way_ent_t);
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  cfg_t              cfg;
  logic [WCNT_W-1:0] ways_eff;
  logic [WAY_W-1:0]  wsel;
  logic [WAY_W-1:0]  residue;

  logic [ADDR_W-1:0] addr_in;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;
  logic              accept;
  logic              adv;

  logic              v1_q;
  logic [ADDR_W-1:0] addr_q;
  logic              wr_q;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;

  logic              vo_q;
  out_t              out_q;

  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  row_wr;
  out_t              res;
  lk_ctl_t           ctl;

  sacc_cfg_regs #(
    .MAX_SETS (MAX_SETS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign ways_eff = ({1'b0, cfg.ways} > 5'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) : WCNT_W'(cfg.ways);
  assign wsel     = WAY_W'(ways_eff - WCNT_W'(1));

  // address split for the row read
  always_comb begin
    addr_in = in_data_i.address & ADDR_MASK;
    set_in  = SET_W'((addr_in >> cfg.obits) & ~({ADDR_W{1'b1}} << cfg.ibits));
    tag_in  = TAG_W'(addr_in >> (4'(cfg.obits) + 4'(cfg.ibits)));
  end

  assign adv        = v1_q && (!vo_q || !out_stall_i);
  assign in_stall_o = v1_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (adv) begin
        v1_q <= 1'b0;
      end
      if (adv) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_in;
      wr_q   <= in_data_i.mode;
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  sacc_tag_ram #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (set_in),
    .we_i    (adv && ctl.row_we),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .rdata_o (row_rd)
  );

  sacc_victim #(
    .MAX_WAYS (MAX_WAYS)
  ) u_victim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv && ctl.lfsr_step),
    .wsel_i    (wsel),
    .residue_o (residue)
  );

  sacc_lookup #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_lookup (
    .cfg_i      (cfg),
    .ways_eff_i (ways_eff),
    .addr_i     (addr_q),
    .write_i    (wr_q),
    .set_i      (set_q),
    .tag_i      (tag_q),
    .row_i      (row_rd),
    .residue_i  (residue),
    .row_o      (row_wr),
    .res_o      (res),
    .ctl_o      (ctl)
  );

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/sacc_checker.sv
// Port-level checker for the cache tag controller, bound to the top level.
// Depends on sacc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_controller_unit_defines.svh"

module sacc_checker
  import sacc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_t                  out_data_o
);

  logic byp_status;
  logic wb_miss;
  logic line_low;
  logic out_held;

  assign byp_status = out_data_o.hit || out_data_o.fill_needed ||
                      out_data_o.writeback_needed || out_data_o.word_write_through;
  assign wb_miss    = out_data_o.fill_needed && !out_data_o.hit;
  assign line_low   = |{out_data_o.line_address[1:0], out_data_o.writeback_address[1:0]};
  assign out_held   = out_valid_o && out_stall_i;

  // no result is offered in the cycle after reset has been seen
  `SACC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "result offered in reset")

  `SACC_ASSERT(a_bypass_clean, out_valid_o && out_data_o.bypass |-> !byp_status, "bypass status")

  // a victim write-back only comes with a line fill on a miss
  `SACC_ASSERT(a_wb_fill, out_valid_o && out_data_o.writeback_needed |-> wb_miss, "wb without fill")

  `SACC_ASSERT(a_line_align, out_valid_o |-> !line_low, "line address not aligned")

  `SACC_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_data_o), "result changed")

endmodule

bind set_assoc_cache_tag_controller_unit sacc_checker u_sacc_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for the set-associative cache tag controller.
// Needs sacc_pkg and set_assoc_cache_tag_controller_unit; lookups are predicted
// in-bench against a local copy of the tag, status and LFSR state.
`timescale 1ns / 1ps

module tb_top;
  import sacc_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int unsigned SET_LIMIT    = 64;
  localparam int unsigned WAY_LIMIT    = 8;
  localparam int unsigned IDX_LIMIT    = $clog2(SET_LIMIT);
  localparam int unsigned LINE_SLOTS   = SET_LIMIT * WAY_LIMIT;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned RANDOM_ITEMS = 82;
  localparam int unsigned RANDOM_PHASES = 12;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // local copy of the controller state
  bit [TAG_W-1:0]  tag_mem    [LINE_SLOTS];
  bit              valid_mem  [LINE_SLOTS];
  bit              dirty_mem  [LINE_SLOTS];
  bit              recent_mem [LINE_SLOTS];
  logic [LFSR_W-1:0] victim_lfsr = LFSR_SEED;

  logic [3:0] cfg_ways  = WAYS_RST;
  logic [2:0] cfg_obits = OBITS_RST;
  logic [2:0] cfg_ibits = IBITS_RST;
  logic       cfg_rnd   = RND_RST;
  logic       cfg_wback = WBACK_RST;

  in_t         access_q [$];
  out_t        predicted_lookups_q [$];
  int unsigned pushed_count = 0;
  int unsigned result_count = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_run    = 0;
  bit          in_accepted  = 1'b0;
  bit          send_quiet   = 1'b0;
  bit          recv_quiet   = 1'b0;
  bit          hold_req     = 1'b0;

  set_assoc_cache_tag_controller_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned eff_ways();
    return (cfg_ways > WAY_LIMIT) ? WAY_LIMIT : cfg_ways;
  endfunction

  function automatic int unsigned eff_obits();
    if (cfg_obits < OB_MIN) return OB_MIN;
    if (cfg_obits > OB_MAX) return OB_MAX;
    return cfg_obits;
  endfunction

  function automatic int unsigned eff_ibits();
    return (cfg_ibits > IDX_LIMIT) ? IDX_LIMIT : cfg_ibits;
  endfunction

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tag lookup with victim choice and status update.
  function automatic out_t predict_lookup(in_t acc);
    out_t              res;
    int unsigned       n_ways, ob, ib, set_idx, base, victim, slot, w;
    int                found;
    logic [ADDR_W-1:0] addr, shifted;
    logic [TAG_W-1:0]  tag;
    longint unsigned   rebuilt;
    res = '0;
    if (cfg_ways == 4'd0) begin
      res.bypass = 1'b1;
      return res;
    end
    n_ways  = eff_ways();
    ob      = eff_obits();
    ib      = eff_ibits();
    addr    = acc.address;
    set_idx = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    shifted = addr >> (ob + ib);
    tag     = shifted[TAG_W-1:0];
    base    = set_idx * WAY_LIMIT;
    found   = -1;
    victim  = 0;
    // highest matching way wins when a tag sits in two ways
    for (w = 0; w < n_ways; w++)
      if (valid_mem[base + w] && tag_mem[base + w] == tag) found = w;
    if (found >= 0) begin
      victim = found;
    end else if (cfg_rnd) begin
      victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_POLY) : (victim_lfsr >> 1);
      victim = victim_lfsr % n_ways;
    end else begin
      // lowest way with recency clear, way 0 if none
      for (w = n_ways; w > 0; w--)
        if (!recent_mem[base + w - 1]) victim = w - 1;
    end
    slot = base + victim;
    res.hit          = (found >= 0);
    res.way_used     = victim[WAYF_W-1:0];
    res.line_address = addr & ~((32'd1 << ob) - 32'd1);
    if (found >= 0) begin
      if (acc.mode) begin
        if (cfg_wback) dirty_mem[slot] = 1'b1;
        else res.word_write_through = 1'b1;
      end
    end else if (acc.mode && !cfg_wback) begin
      // write-through miss: no allocation
      res.word_write_through = 1'b1;
    end else begin
      res.fill_needed = 1'b1;
      if (valid_mem[slot] && dirty_mem[slot]) begin
        rebuilt = 64'(tag_mem[slot]);
        rebuilt = ((rebuilt << ib) | set_idx) << ob;
        res.writeback_needed  = 1'b1;
        res.writeback_address = rebuilt[ADDR_W-1:0];
      end
      tag_mem[slot]   = tag;
      valid_mem[slot] = 1'b1;
      dirty_mem[slot] = acc.mode;
      for (w = 0; w < n_ways; w++) recent_mem[base + w] = 1'b0;
      recent_mem[slot] = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_access(logic [ADDR_W-1:0] addr, logic mode);
    in_t item;
    item.address = addr;
    item.mode    = mode;
    access_q.push_back(item);
    pushed_count++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WAYS:   cfg_ways  = val;
      CFG_OFFSET: cfg_obits = val[2:0];
      CFG_INDEX:  cfg_ibits = val[2:0];
      CFG_RANDOM: cfg_rnd   = val[0];
      CFG_WBACK:  cfg_wback = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [3:0] ways, logic [3:0] obits, logic [3:0] ibits,
                                logic [3:0] rnd, logic [3:0] wback);
    write_reg(CFG_WAYS, ways);
    write_reg(CFG_OFFSET, obits);
    write_reg(CFG_INDEX, ibits);
    write_reg(CFG_RANDOM, rnd);
    write_reg(CFG_WBACK, wback);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (result_count < pushed_count) @(negedge clk_i);
  endtask

  // Access driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      in_accepted = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (access_q.size() != 0) begin
        in_data_i  <= access_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap = pick_gap(send_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_run = LONG_HOLD;
      end
      if (stall_run != 0) begin
        stall_run--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_run = pick_gap(recv_quiet);
      end
    end
  end

  // Monitor: check results first, then predict the access taken on this edge
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_count++;
        if (predicted_lookups_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, line %h hit %b", $time,
                   out_data_o.line_address, out_data_o.hit);
          errors++;
        end else begin
          want = predicted_lookups_q.pop_front();
          check_field("bypass", want.bypass, out_data_o.bypass);
          check_field("hit", want.hit, out_data_o.hit);
          check_field("way_used", want.way_used, out_data_o.way_used);
          check_field("fill_needed", want.fill_needed, out_data_o.fill_needed);
          check_field("line_address", want.line_address, out_data_o.line_address);
          check_field("writeback_needed", want.writeback_needed,
                      out_data_o.writeback_needed);
          check_field("writeback_address", want.writeback_address,
                      out_data_o.writeback_address);
          check_field("word_write_through", want.word_write_through,
                      out_data_o.word_write_through);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted_lookups_q.push_back(predict_lookup(in_data_i));
        in_accepted = 1'b1;
      end
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned       phase, i, ob, ib;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tag_pool [$];
    int unsigned       set_pool [4];

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // basic fill, hit, dirty and eviction with writeback
    apply_settings(4'd2, 4'd2, 4'd1, 4'd0, 4'd1);
    push_access(32'h0000_0000, 1'b0);
    push_access(32'h0000_0000, 1'b0);
    push_access(32'h0000_0003, 1'b1);
    push_access(32'h0000_0008, 1'b1);
    push_access(32'h0000_0010, 1'b0);
    push_access(32'hFFFF_FFFF, 1'b0);
    push_access(32'hFFFF_FFFC, 1'b1);
    wait_drained();

    // write-through: write miss without allocation, write hit
    apply_settings(4'd2, 4'd2, 4'd1, 4'hE, 4'd0);
    push_access(32'h0000_0020, 1'b1);
    push_access(32'hFFFF_FFFC, 1'b1);
    push_access(32'h0000_0020, 1'b0);
    push_access(32'h0000_0024, 1'b1);
    wait_drained();

    // bypass
    apply_settings(4'd0, 4'd2, 4'd0, 4'd0, 4'd1);
    push_access(32'hFFFF_FFFF, 1'b0);
    push_access(32'h0000_0000, 1'b1);
    wait_drained();

    // too many ways, offset and index above range, random victims
    apply_settings(4'd15, 4'd7, 4'd7, 4'd1, 4'd1);
    push_access(32'h0000_0800, 1'b0);
    push_access(32'h0000_1000, 1'b1);
    push_access(32'h0000_1800, 1'b0);
    push_access(32'hFFFF_F800, 1'b1);
    wait_drained();

    // shrinking then growing the ways leaves one tag in two ways
    apply_settings(4'd2, 4'd0, 4'd0, 4'd0, 4'd1);
    push_access(32'h0000_A000, 1'b0);
    push_access(32'h0000_B000, 1'b0);
    wait_drained();
    apply_settings(4'd1, 4'd0, 4'd0, 4'd0, 4'd1);
    push_access(32'h0000_A000, 1'b0);
    wait_drained();
    apply_settings(4'd2, 4'd0, 4'd0, 4'd0, 4'd1);
    push_access(32'h0000_A000, 1'b0);
    push_access(32'h0000_B000, 1'b0);
    wait_drained();
    apply_settings(4'd1, 4'd0, 4'd0, 4'd0, 4'd1);
    push_access(32'h0000_B000, 1'b0);
    wait_drained();
    apply_settings(4'd2, 4'd0, 4'd0, 4'd0, 4'd1);
    push_access(32'h0000_B000, 1'b1);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(4'd8, 4'd2, 4'd3, 4'd0, 4'd1);
        1: apply_settings(4'd15, 4'd7, 4'd7, 4'd1, 4'd1);
        2: apply_settings(4'd4, 4'd0, 4'd6, 4'd1, 4'd0);
        3: apply_settings(4'd1, 4'd5, 4'd0, 4'd0, 4'd0);
        4: apply_settings(4'd0, 4'd15, 4'd15, 4'd15, 4'd15);
        5: apply_settings(4'd3, 4'd3, 4'd2, 4'd14, 4'd14);
        default:
          apply_settings(($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      send_quiet = (phase % 3 == 0) || (phase == 1);
      recv_quiet = (phase % 3 == 0);
      // fill the pipe against a long result-side hold
      if (phase == 1) hold_req = 1'b1;

      ob = eff_obits();
      ib = eff_ibits();
      tag_pool.delete();
      for (i = 0; i < eff_ways() + 2; i++) tag_pool.push_back($urandom());
      for (i = 0; i < 4; i++) set_pool[i] = $urandom_range(0, (1 << ib) - 1);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 15)
          addr = $urandom();
        else
          addr = (tag_pool[$urandom_range(0, tag_pool.size() - 1)] << (ob + ib)) |
                 (set_pool[$urandom_range(0, 3)] << ob) |
                 $urandom_range(0, (1 << ob) - 1);
        push_access(addr, 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
